>>> design/pdfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfu_pkg: shared types and the code table for the PDF text transcoder
// Holds the decode mode codes, the state and decode result structs, the
// WinAnsi table for bytes 0x80 to 0x9F and the UTF-8 encoder function.
// ----------------------------------------------------------------------------
package pdfu_pkg;

   localparam int SEQ_BYTES = 6;
   localparam int SEQ_BITS  = SEQ_BYTES * 8;

   localparam logic [7:0] BOM_HIGH = 8'hFE;
   localparam logic [7:0] BOM_LOW  = 8'hFF;

   typedef enum logic [1:0] {
      MODE_AWAIT2 = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_WIDE   = 2'd2,
      MODE_IDLE   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [7:0] held;
      logic       pending;
   } state_type;

   typedef struct packed {
      logic [SEQ_BITS-1:0] seq;
      logic [2:0]          count;
      state_type           next;
   } dec_out_type;

   typedef struct packed {
      logic [23:0] seq;
      logic [1:0]  len;
   } utf8_type;

   // Code points for bytes 0x80 to 0x9F of the WinAnsi code.
   function automatic logic [15:0] c1_code(input logic [4:0] idx);
      logic [15:0] cp;
      case (idx)
         5'd0:  cp = 16'h20AC;
         5'd1:  cp = 16'h0081;
         5'd2:  cp = 16'h201A;
         5'd3:  cp = 16'h0192;
         5'd4:  cp = 16'h201E;
         5'd5:  cp = 16'h2026;
         5'd6:  cp = 16'h2020;
         5'd7:  cp = 16'h2021;
         5'd8:  cp = 16'h02C6;
         5'd9:  cp = 16'h2030;
         5'd10: cp = 16'h0160;
         5'd11: cp = 16'h2039;
         5'd12: cp = 16'h0152;
         5'd13: cp = 16'h008D;
         5'd14: cp = 16'h017D;
         5'd15: cp = 16'h008F;
         5'd16: cp = 16'h0090;
         5'd17: cp = 16'h2018;
         5'd18: cp = 16'h2019;
         5'd19: cp = 16'h201C;
         5'd20: cp = 16'h201D;
         5'd21: cp = 16'h2022;
         5'd22: cp = 16'h2013;
         5'd23: cp = 16'h2014;
         5'd24: cp = 16'h02DC;
         5'd25: cp = 16'h2122;
         5'd26: cp = 16'h0161;
         5'd27: cp = 16'h203A;
         5'd28: cp = 16'h0153;
         5'd29: cp = 16'h009D;
         5'd30: cp = 16'h017E;
         default: cp = 16'h0178;
      endcase
      return cp;
   endfunction

   function automatic logic [15:0] win_code(input logic [7:0] b);
      logic [15:0] cp;
      if (b[7:5] == 3'b100) begin
         cp = c1_code(b[4:0]);
      end else begin
         cp = {8'h00, b};
      end
      return cp;
   endfunction

   // Byte sequence is left-justified: the first byte sits in bits 23:16.
   function automatic utf8_type utf8_enc(input logic [15:0] cp);
      utf8_type r;
      if (cp[15:7] == 9'd0) begin
         r.seq = {cp[7:0], 16'h0000};
         r.len = 2'd1;
      end else if (cp[15:11] == 5'd0) begin
         r.seq = {3'b110, cp[10:6], 2'b10, cp[5:0], 8'h00};
         r.len = 2'd2;
      end else begin
         r.seq = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
         r.len = 2'd3;
      end
      return r;
   endfunction

endpackage

>>> design/pdfu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfu_decode: per-word decode of one string byte
// Works out the next decode state and the UTF-8 bytes (zero to six) that one
// input word yields, packed left-justified into a six-byte sequence.
// ----------------------------------------------------------------------------
module pdfu_decode (
   input  logic [7:0]           in_byte,
   input  logic                 first_of_string,
   input  logic                 last_of_string,
   input  pdfu_pkg::state_type  state,
   output pdfu_pkg::dec_out_type dec
);
   import pdfu_pkg::*;

   logic        use_a;
   logic        use_b;
   logic [15:0] cp_a;
   utf8_type    enc_a;
   utf8_type    enc_b;
   logic [1:0]  len_a;
   logic [1:0]  len_b;
   logic [4:0]  shift_b;
   state_type   next;

   always_comb begin
      use_a = 1'b0;
      use_b = 1'b0;
      cp_a  = win_code(in_byte);
      next  = state;
      if (first_of_string || state.mode == MODE_IDLE) begin
         next.pending = 1'b0;
         if (last_of_string) begin
            use_a = 1'b1;
         end else begin
            next.held = in_byte;
            next.mode = MODE_AWAIT2;
         end
      end else if (state.mode == MODE_AWAIT2) begin
         if (state.held == BOM_HIGH && in_byte == BOM_LOW) begin
            next.mode    = MODE_WIDE;
            next.pending = 1'b0;
         end else begin
            use_a     = 1'b1;
            use_b     = 1'b1;
            cp_a      = win_code(state.held);
            next.mode = MODE_SINGLE;
         end
      end else if (state.mode == MODE_SINGLE) begin
         use_a = 1'b1;
      end else begin
         if (!state.pending) begin
            next.held    = in_byte;
            next.pending = 1'b1;
         end else begin
            use_a        = 1'b1;
            cp_a         = {state.held, in_byte};
            next.pending = 1'b0;
         end
      end
      if (last_of_string) begin
         next.mode    = MODE_IDLE;
         next.pending = 1'b0;
      end
   end

   assign enc_a   = utf8_enc(cp_a);
   assign enc_b   = utf8_enc(win_code(in_byte));
   assign len_a   = use_a ? enc_a.len : 2'd0;
   assign len_b   = use_b ? enc_b.len : 2'd0;
   assign shift_b = {len_a, 3'b000};

   always_comb begin
      dec.seq   = ({use_a ? enc_a.seq : 24'h0, 24'h0})
                | ({use_b ? enc_b.seq : 24'h0, 24'h0} >> shift_b);
      dec.count = {1'b0, len_a} + {1'b0, len_b};
      dec.next  = next;
   end

endmodule

>>> design/pdf_text_bytes_to_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdf_text_bytes_to_utf8: PDF text string to UTF-8 transcoder
// Converts the bytes of PDF text strings (WinAnsi or FE FF marked UTF-16BE)
// into a stream of UTF-8 bytes, one byte per output word.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one raw string byte per word, with flags on the
// first and last byte of each string. The rsp channel carries one UTF-8 byte
// per word; rsp_run_last closes the output of each input word and
// rsp_string_end closes the whole string. A string's last byte that yields
// no output produces a single word with rsp_byte_valid low.
// An accepted word sits in an input register; once the shift register is free
// it is decoded and its output bytes are loaded into a six-byte shift register,
// from which the first output word is offered. The shift register drains one
// byte per cycle while the receiver does not stall, and is reloaded on the
// cycle its last byte leaves. An input word yields one output byte for ASCII,
// up to three for a 16-bit unit, and up to six for the second byte of a
// single-byte string.
// While the output drains, the next input word waits in the input register
// and req_stall is raised only once that register is full and blocked.
// When the receiver stalls, the current output word holds unchanged.
// Reset empties both registers and returns the decoder to "awaiting second
// byte" with a held byte of zero.
// ----------------------------------------------------------------------------
module pdf_text_bytes_to_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import pdfu_pkg::*;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_first_ff, in_first_in;
   logic       in_last_ff, in_last_in;

   // Decoder state that carries across words.
   state_type  state_ff, state_in;

   // Output shift register: the byte on offer is always the top byte.
   logic [SEQ_BITS-1:0] buf_seq_ff, buf_seq_in;
   logic [2:0]          buf_cnt_ff, buf_cnt_in;
   logic                buf_marker_ff, buf_marker_in;
   logic                buf_last_ff, buf_last_in;

   dec_out_type dec;
   logic        pop;
   logic        buf_free;
   logic        consume;
   logic        load;
   logic        accept;

   pdfu_decode u_decode (
      .in_byte         (in_byte_ff),
      .first_of_string (in_first_ff),
      .last_of_string  (in_last_ff),
      .state           (state_ff),
      .dec             (dec)
   );

   // The buffer can take a new word when it is empty or its final byte is
   // leaving in this cycle.
   assign pop      = rsp_valid && !rsp_stall;
   assign buf_free = (buf_cnt_ff == 3'd0) || (buf_cnt_ff == 3'd1 && pop);
   assign consume  = in_valid_ff && buf_free;
   // A word with no bytes loads nothing unless it ends a string, where it
   // leaves an empty end marker.
   assign load     = consume && (dec.count != 3'd0 || in_last_ff);
   assign req_stall = in_valid_ff && !consume;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_first_in = in_first_ff;
      in_last_in  = in_last_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
         in_first_in = req_first_of_string;
         in_last_in  = req_last_of_string;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   assign state_in = consume ? dec.next : state_ff;

   always_comb begin
      buf_seq_in    = buf_seq_ff;
      buf_cnt_in    = buf_cnt_ff;
      buf_marker_in = buf_marker_ff;
      buf_last_in   = buf_last_ff;
      if (load) begin
         buf_seq_in    = dec.seq;
         buf_marker_in = (dec.count == 3'd0);
         buf_cnt_in    = (dec.count == 3'd0) ? 3'd1 : dec.count;
         buf_last_in   = in_last_ff;
      end else if (pop) begin
         buf_seq_in = buf_seq_ff << 8;
         buf_cnt_in = buf_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= '{mode: MODE_AWAIT2, held: 8'h00, pending: 1'b0};
         buf_cnt_ff    <= 3'd0;
         buf_marker_ff <= 1'b0;
         buf_last_ff   <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         state_ff      <= state_in;
         buf_cnt_ff    <= buf_cnt_in;
         buf_marker_ff <= buf_marker_in;
         buf_last_ff   <= buf_last_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_first_ff <= in_first_in;
      in_last_ff  <= in_last_in;
      buf_seq_ff  <= buf_seq_in;
   end

   assign rsp_valid      = (buf_cnt_ff != 3'd0);
   assign rsp_out_byte   = buf_seq_ff[SEQ_BITS-1 -: 8];
   assign rsp_byte_valid = !buf_marker_ff;
   assign rsp_run_last   = (buf_cnt_ff == 3'd1);
   assign rsp_string_end = (buf_cnt_ff == 3'd1) && buf_last_ff;

   // An empty end marker on offer is always a lone word.
   assert property (@(posedge clock) disable iff (reset)
      (buf_marker_ff && rsp_valid) |-> buf_cnt_ff == 3'd1)
      else $error("end marker shares the buffer with other bytes");

   // An empty word only ever closes a string.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_string_end)
      else $error("empty word without string end");

   // A pending high half exists only in 16-bit mode.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.pending |-> state_ff.mode == MODE_WIDE)
      else $error("pending half outside 16-bit mode");

   // Decoding a string's last byte leaves the decoder idle.
   assert property (@(posedge clock) disable iff (reset)
      (consume && in_last_ff) |=> state_ff.mode == MODE_IDLE)
      else $error("decoder not idle after string end");

   // The final byte leaving with no reload empties the output.
   assert property (@(posedge clock) disable iff (reset)
      (pop && buf_cnt_ff == 3'd1 && !load) |=> !rsp_valid)
      else $error("output still valid after draining");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the PDF text string to UTF-8 transcoder
// Drives framed string bytes through the req channel, predicts the UTF-8
// words each accepted byte should produce and checks every rsp word in order.
// A short hand-written table comes first, then randomly built strings.
// ----------------------------------------------------------------------------
module testbench;
   import pdfu_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_WORDS = 454;
   localparam int HOLD_AT      = 176;   // input words accepted before the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;    // idle time after the last expected word
   localparam int QUIET_LIMIT  = 2000;  // cycles without any accepted word
   localparam int DIR_ROWS     = 26;

   // One input word plus, for table rows, the hand-written expectation.
   // When typed is set, the rsp words are n_exp bytes taken from exp_seq
   // (first byte in bits 23:16), all with rsp_byte_valid equal to exp_valid.
   typedef struct packed {
      logic [7:0]  in_byte;
      logic        first;
      logic        last;
      logic        typed;
      logic [2:0]  n_exp;
      logic [23:0] exp_seq;
      logic        exp_valid;
      logic        exp_end;
   } text_row_type;

   // One word on the rsp channel.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       run_last;
      logic       str_end;
   } utf8_word_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   // Directed table. It opens right after reset with a byte that has no first
   // mark, then walks the undefined WinAnsi codes, a mark-only string, a
   // 16-bit string with a lone trailing byte, and a string abandoned by a new
   // first mark while half a code unit is pending.
   localparam text_row_type DIR_TABLE [DIR_ROWS] = '{
      '{8'h41, 1'b0, 1'b0, 1'b1, 3'd2, 24'h004100, 1'b1, 1'b0},
      '{8'h7F, 1'b0, 1'b1, 1'b1, 3'd1, 24'h7F0000, 1'b1, 1'b1},
      '{8'h80, 1'b1, 1'b1, 1'b1, 3'd3, 24'hE282AC, 1'b1, 1'b1},
      '{8'hFF, 1'b0, 1'b0, 1'b1, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h81, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h8D, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h8F, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h90, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h9D, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h9F, 1'b0, 1'b1, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'hFE, 1'b1, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 1'b1, 3'd1, 24'h000000, 1'b0, 1'b1},
      '{8'hFE, 1'b1, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h07, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b1, 3'd3, 24'hEFBFBF, 1'b1, 1'b0},
      '{8'hD8, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h12, 1'b0, 1'b1, 1'b1, 3'd1, 24'h000000, 1'b0, 1'b1},
      '{8'hFE, 1'b1, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h20, 1'b0, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h41, 1'b1, 1'b0, 1'b0, 3'd0, 24'h000000, 1'b0, 1'b0},
      '{8'h42, 1'b0, 1'b1, 1'b1, 3'd2, 24'h414200, 1'b1, 1'b1}
   };

   // Code points of WinAnsi bytes 0x80 to 0x9F; every other byte maps to itself.
   localparam logic [15:0] WINANSI_HIGH [32] = '{
      16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
      16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_first_of_string = 1'b0;
   logic       req_last_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_run_last;
   logic       rsp_string_end;

   // Stimulus, expectations and bookkeeping.
   text_row_type  stim_words [$];
   utf8_word_type utf8_expected [$];
   utf8_word_type step_words [$];
   int         n_accepted = 0;
   int         offered_idx = -1;
   int         n_checked = 0;
   int         n_string_ends = 0;
   int         n_empty_marks = 0;
   int         quiet_cycles = 0;
   int         errors = 0;

   // Predictor state, mirroring what the decoder holds after reset.
   mode_type   dec_mode = MODE_AWAIT2;
   logic [7:0] dec_held = 8'h00;
   logic       dec_pending = 1'b0;

   pdf_text_bytes_to_utf8 DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_in_byte         (req_in_byte),
      .req_first_of_string (req_first_of_string),
      .req_last_of_string  (req_last_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_valid      (rsp_byte_valid),
      .rsp_run_last        (rsp_run_last),
      .rsp_string_end      (rsp_string_end)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic void push_result(input logic [7:0] data, input logic valid);
      utf8_word_type w;
      w.data     = data;
      w.valid    = valid;
      w.run_last = 1'b0;
      w.str_end  = 1'b0;
      step_words.insert(step_words.size(), w);
   endfunction

   // UTF-8 encoding of one 16-bit code unit: one, two or three bytes.
   function automatic void push_code_point(input logic [15:0] cp);
      if (cp < 16'h0080) begin
         push_result(cp[7:0], 1'b1);
      end else if (cp < 16'h0800) begin
         push_result(8'hC0 | {3'b000, cp[10:6]}, 1'b1);
         push_result(8'h80 | {2'b00, cp[5:0]}, 1'b1);
      end else begin
         push_result(8'hE0 | {4'h0, cp[15:12]}, 1'b1);
         push_result(8'h80 | {2'b00, cp[11:6]}, 1'b1);
         push_result(8'h80 | {2'b00, cp[5:0]}, 1'b1);
      end
   endfunction

   function automatic void push_winansi(input logic [7:0] b);
      if (b >= 8'h80 && b < 8'hA0) begin
         push_code_point(WINANSI_HIGH[b[4:0]]);
      end else begin
         push_code_point({8'h00, b});
      end
   endfunction

   // Works out the rsp words caused by one accepted input word and leaves
   // them in step_words, with the closing flags on the final one.
   function automatic void predict_utf8(input logic [7:0] b, input logic first,
                                        input logic last);
      step_words.delete();
      if (first || dec_mode == MODE_IDLE) begin
         // A new string starts; a half unit of an abandoned string is lost.
         dec_pending = 1'b0;
         if (last) begin
            push_winansi(b);
         end else begin
            dec_held = b;
            dec_mode = MODE_AWAIT2;
         end
      end else if (dec_mode == MODE_AWAIT2) begin
         if (dec_held == BOM_HIGH && b == BOM_LOW) begin
            dec_mode    = MODE_WIDE;
            dec_pending = 1'b0;
         end else begin
            push_winansi(dec_held);
            push_winansi(b);
            dec_mode = MODE_SINGLE;
         end
      end else if (dec_mode == MODE_SINGLE) begin
         push_winansi(b);
      end else if (!dec_pending) begin
         dec_held    = b;
         dec_pending = 1'b1;
      end else begin
         push_code_point({dec_held, b});
         dec_pending = 1'b0;
      end

      if (last) begin
         // A lone trailing byte is dropped here; an empty marker closes the
         // string when the last byte gave nothing.
         dec_mode    = MODE_IDLE;
         dec_pending = 1'b0;
         if (step_words.size() == 0) begin
            push_result(8'h00, 1'b0);
         end
      end
      if (step_words.size() > 0) begin
         step_words[step_words.size() - 1].run_last = 1'b1;
         step_words[step_words.size() - 1].str_end  = last;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void queue_word(input logic [7:0] b, input logic first,
                                      input logic last);
      text_row_type r;
      r         = '0;
      r.in_byte = b;
      r.first   = first;
      r.last    = last;
      stim_words.insert(stim_words.size(), r);
   endfunction

   // Text bytes biased toward the interesting regions: ASCII, the WinAnsi
   // upper-half codes, the mark bytes and small high halves that give one-
   // and two-byte UTF-8 in a 16-bit string.
   function automatic logic [7:0] pick_text_byte();
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: b = 8'($urandom_range(0, 255));
         4, 5:       b = 8'($urandom_range(8'h20, 8'h7E));
         6, 7:       b = 8'($urandom_range(8'h80, 8'h9F));
         8:          b = $urandom_range(0, 1) ? BOM_HIGH : BOM_LOW;
         default:    b = 8'($urandom_range(0, 7));
      endcase
      return b;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %02h, got %02h", $time, field, want, got);
         errors++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: both channels are sampled at the rising edge, before the block's
   // own registers update, so every read sees the values set up at the
   // preceding falling edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      utf8_word_type got;
      utf8_word_type want;
      text_row_type  row;
      logic          moved;
      if (!reset) begin
         moved = 1'b0;

         // Input word accepted: predict it, or take the typed expectation
         // when the table row carries one.
         if (req_valid && !req_stall) begin
            row = stim_words[n_accepted];
            predict_utf8(req_in_byte, req_first_of_string, req_last_of_string);
            if (row.typed) begin
               for (int i = 0; i < int'(row.n_exp); i++) begin
                  want.data     = row.exp_seq[23 - 8 * i -: 8];
                  want.valid    = row.exp_valid;
                  want.run_last = (i == int'(row.n_exp) - 1);
                  want.str_end  = (i == int'(row.n_exp) - 1) && row.exp_end;
                  utf8_expected.insert(utf8_expected.size(), want);
               end
            end else begin
               foreach (step_words[i]) begin
                  utf8_expected.insert(utf8_expected.size(), step_words[i]);
               end
            end
            n_accepted++;
            moved = 1'b1;
         end

         // Output word accepted: compare field by field with the oldest one.
         if (rsp_valid && !rsp_stall) begin
            got.data     = rsp_out_byte;
            got.valid    = rsp_byte_valid;
            got.run_last = rsp_run_last;
            got.str_end  = rsp_string_end;
            if (utf8_expected.size() == 0) begin
               $display("%0t: unexpected UTF-8 word, expected none, got %02h/%b%b%b",
                        $time, got.data, got.valid, got.run_last, got.str_end);
               errors++;
            end else begin
               want = utf8_expected.pop_front();
               check_field("rsp_out_byte", want.data, got.data);
               check_field("rsp_byte_valid", {7'd0, want.valid}, {7'd0, got.valid});
               check_field("rsp_run_last", {7'd0, want.run_last}, {7'd0, got.run_last});
               check_field("rsp_string_end", {7'd0, want.str_end}, {7'd0, got.str_end});
            end
            n_checked++;
            if (got.str_end) n_string_ends++;
            if (!got.valid) n_empty_marks++;
            moved = 1'b1;
         end

         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender: offers the stimulus words in bursts of random length separated
   // by random gaps. A word that is offered and not yet taken holds still;
   // once it is taken the next one may follow at the same falling edge, so
   // req_valid gets a single assignment per step.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      int burst_left;
      int gap_left;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else if (!req_valid || offered_idx != n_accepted) begin
         if (n_accepted >= stim_words.size()) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else begin
            req_valid           <= 1'b1;
            req_in_byte         <= stim_words[n_accepted].in_byte;
            req_first_of_string <= stim_words[n_accepted].first;
            req_last_of_string  <= stim_words[n_accepted].last;
            offered_idx = n_accepted;
            if (burst_left <= 1) begin
               // A third of the bursts run straight into the next one.
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stalls in phases of random length, each with its own style.
   // Once, after HOLD_AT input words, it holds off while the sender keeps
   // offering, so the shift register and the input register fill and the
   // block pushes back with req_stall.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      stall_style_type stall_style;
      int              phase_left;
      int              hold_left;
      logic            hold_done;
      logic [1:0]      beat;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_style = STALL_NONE;
         phase_left  = 0;
         hold_left   = 0;
         hold_done   = 1'b0;
         beat        = 2'd0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            phase_left  = $urandom_range(20, 120);
         end
         phase_left--;
         beat++;
         case (stall_style)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 99) < 70);
            STALL_PERIODIC: rsp_stall <= (beat != 2'd0);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   // Watchdog: nothing accepted on either channel for too long ends the run.
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no word moved for %0d cycles, %0d UTF-8 words still expected",
               $time, QUIET_LIMIT, utf8_expected.size());
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence: build the stimulus, release reset, wait for the last
   // expected word, let the block settle and report.
   // ------------------------------------------------------------------------
   initial begin
      logic [7:0] text [$];
      int         kind;
      int         count;
      logic       abandoned;

      // Directed table first, walked row by row.
      for (int i = 0; i < DIR_ROWS; i++) stim_words.insert(stim_words.size(), DIR_TABLE[i]);

      // Random part. Most of it is well-formed strings with random content,
      // half of them FE FF marked with an occasional odd trailing byte; the
      // rest is strings cut short by a new first mark, bytes arriving while
      // idle, and words whose flags are pure noise.
      while (stim_words.size() < DIR_ROWS + RANDOM_WORDS) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            abandoned = (kind >= 70);
            text.delete();
            if ($urandom_range(0, 1) == 1) begin
               text.insert(text.size(), BOM_HIGH);
               text.insert(text.size(), BOM_LOW);
               count = 2 * $urandom_range(0, 5) + (($urandom_range(0, 3) == 0) ? 1 : 0);
            end else begin
               count = $urandom_range(1, 10);
            end
            for (int i = 0; i < count; i++) text.insert(text.size(), pick_text_byte());
            foreach (text[i]) begin
               queue_word(text[i], i == 0, !abandoned && i == text.size() - 1);
            end
         end else if (kind < 90) begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++) begin
               queue_word(pick_text_byte(), 1'b0, 1'($urandom_range(0, 1)));
            end
         end else begin
            count = $urandom_range(1, 4);
            for (int i = 0; i < count; i++) begin
               queue_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
         end
      end

      // Reset is applied once and released at a falling edge like every other input.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (!(n_accepted == stim_words.size() && utf8_expected.size() == 0)) begin
         @(posedge clock);
      end
      // Anything that turns up now is flagged by the monitor as unexpected.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (utf8_expected.size() != 0) begin
         $display("%0t: %0d UTF-8 words expected but never seen", $time,
                  utf8_expected.size());
         errors++;
      end
      $display("Transcoded %0d input words into %0d UTF-8 words: %0d string ends, %0d empty markers.",
               n_accepted, n_checked, n_string_ends, n_empty_marks);
      $display("Mixed WinAnsi and FE FF strings, abandoned strings, idle bytes, a %0d-cycle hold-off; %0d errors.",
               HOLD_CYCLES, errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
